[design/ising_contact_lattice_update_assert.svh]
// Assertion macros for the lattice update engine.
// Used by ising_contact_lattice_update.sv; expects clk and rst in scope.
`ifndef ISING_CONTACT_LATTICE_UPDATE_ASSERT_SVH
`define ISING_CONTACT_LATTICE_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define ICLU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ICLU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ICLU_ASSERT_IMP(label, ante, cons, msg)
`define ICLU_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[design/iclu_pkg.sv]
// Types and constants of the lattice update engine.
// No dependencies.
`default_nettype none
package iclu_pkg;

  typedef enum logic [1:0] {
    SITE_EMPTY = 2'd0,
    SITE_OCC   = 2'd1,
    SITE_UP    = 2'd2,
    SITE_DOWN  = 2'd3
  } site_t;

  typedef enum logic {
    OP_CONTACT = 1'b0,
    OP_SPIN    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_YM = 2'd0,
    DIR_YP = 2'd1,
    DIR_XM = 2'd2,
    DIR_XP = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    REG_COUPLING = 3'd0,
    REG_BIRTH    = 3'd1,
    REG_DEATH    = 3'd2,
    REG_POLARIZE = 3'd3,
    REG_ACC_DE2  = 3'd4,
    REG_ACC_DE4  = 3'd5,
    REG_ACC_DE6  = 3'd6,
    REG_ACC_DE8  = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD1   = 5'b00100,
    S_RD2   = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  localparam int THR_W = 33;
  localparam int CNT_W = 17;

  localparam logic             RST_COUPLING = 1'b1;
  localparam logic [THR_W-1:0] RST_BIRTH    = 33'd4294967296;
  localparam logic [THR_W-1:0] RST_DEATH    = 33'd429497;
  localparam logic [THR_W-1:0] RST_POLARIZE = 33'd429496730;
  localparam logic [THR_W-1:0] RST_ACC_DE2  = 33'd1779705598;
  localparam logic [THR_W-1:0] RST_ACC_DE4  = 33'd737488834;
  localparam logic [THR_W-1:0] RST_ACC_DE6  = 33'd305595513;
  localparam logic [THR_W-1:0] RST_ACC_DE8  = 33'd126628521;

endpackage
`default_nettype wire

[design/ising_contact_lattice_update.sv]
// Lattice update engine: contact process moves and Metropolis spin moves on a torus.
// Depends on iclu_pkg and ising_contact_lattice_update_assert.svh.
//
// Issue a move with start while busy is low; its result appears on old_state,
// new_state and occupied_count for exactly one cycle with done high, and cannot
// be held off. A contact move keeps the block busy through state S_RD1 and a
// spin move through S_RD1, S_RD2 and S_EVAL, as the lattice memory has two
// registered read ports and must deliver five sites for a spin move. After
// reset a clearing pass writes every one of the 2^(XW+YW) memory rows, with
// XW = clog2(LATTICE_X) and YW = clog2(LATTICE_Y), during which busy stays
// high; register writes are taken at any time. Coordinates wrap modulo the size.
`default_nettype none
`include "ising_contact_lattice_update_assert.svh"
module ising_contact_lattice_update #(
  parameter int LATTICE_X = 256,
  parameter int LATTICE_Y = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [7:0]  site_x,
  input  wire logic [7:0]  site_y,
  input  wire logic [1:0]  direction,
  input  wire logic [31:0] rand_event,
  input  wire logic [31:0] rand_second,
  input  wire logic        spin_pick,
  output logic             done,
  output logic [1:0]       old_state,
  output logic [1:0]       new_state,
  output logic [16:0]      occupied_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int XW    = $clog2(LATTICE_X);
  localparam int YW    = $clog2(LATTICE_Y);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int THR_W = iclu_pkg::THR_W;
  localparam int CNT_W = iclu_pkg::CNT_W;

  localparam logic [XW-1:0] X_LAST = XW'(LATTICE_X - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(LATTICE_Y - 1);
  localparam logic [XW-1:0] X_MID  = XW'(LATTICE_X / 2);
  localparam logic [YW-1:0] Y_MID  = YW'(LATTICE_Y / 2);
  localparam logic [AW-1:0] CENTRE = {X_MID, Y_MID};

  // configuration
  logic             coupling_negative;
  logic [THR_W-1:0] birth_threshold;
  logic [THR_W-1:0] death_threshold;
  logic [THR_W-1:0] polarize_threshold;
  logic [THR_W-1:0] accept_de2;
  logic [THR_W-1:0] accept_de4;
  logic [THR_W-1:0] accept_de6;
  logic [THR_W-1:0] accept_de8;
  logic             cfg_we;
  iclu_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = iclu_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_negative  <= iclu_pkg::RST_COUPLING;
      birth_threshold    <= iclu_pkg::RST_BIRTH;
      death_threshold    <= iclu_pkg::RST_DEATH;
      polarize_threshold <= iclu_pkg::RST_POLARIZE;
      accept_de2         <= iclu_pkg::RST_ACC_DE2;
      accept_de4         <= iclu_pkg::RST_ACC_DE4;
      accept_de6         <= iclu_pkg::RST_ACC_DE6;
      accept_de8         <= iclu_pkg::RST_ACC_DE8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        iclu_pkg::REG_COUPLING: coupling_negative  <= pwdata[0];
        iclu_pkg::REG_BIRTH:    birth_threshold    <= pwdata[THR_W-1:0];
        iclu_pkg::REG_DEATH:    death_threshold    <= pwdata[THR_W-1:0];
        iclu_pkg::REG_POLARIZE: polarize_threshold <= pwdata[THR_W-1:0];
        iclu_pkg::REG_ACC_DE2:  accept_de2         <= pwdata[THR_W-1:0];
        iclu_pkg::REG_ACC_DE4:  accept_de4         <= pwdata[THR_W-1:0];
        iclu_pkg::REG_ACC_DE6:  accept_de6         <= pwdata[THR_W-1:0];
        iclu_pkg::REG_ACC_DE8:  accept_de8         <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      iclu_pkg::REG_COUPLING: prdata = {63'd0, coupling_negative};
      iclu_pkg::REG_BIRTH:    prdata = {31'd0, birth_threshold};
      iclu_pkg::REG_DEATH:    prdata = {31'd0, death_threshold};
      iclu_pkg::REG_POLARIZE: prdata = {31'd0, polarize_threshold};
      iclu_pkg::REG_ACC_DE2:  prdata = {31'd0, accept_de2};
      iclu_pkg::REG_ACC_DE4:  prdata = {31'd0, accept_de4};
      iclu_pkg::REG_ACC_DE6:  prdata = {31'd0, accept_de6};
      iclu_pkg::REG_ACC_DE8:  prdata = {31'd0, accept_de8};
      default:                prdata = '0;
    endcase
  end

  // coordinate wrap tables
  logic [XW-1:0] xmod [256];
  logic [YW-1:0] ymod [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign xmod[i] = XW'(i % LATTICE_X);
    assign ymod[i] = YW'(i % LATTICE_Y);
  end

  logic [XW-1:0] in_x, in_xm, in_xp;
  logic [YW-1:0] in_y, in_ym, in_yp;

  assign in_x  = xmod[site_x];
  assign in_y  = ymod[site_y];
  assign in_xm = (in_x == '0)     ? X_LAST : in_x - 1'b1;
  assign in_xp = (in_x == X_LAST) ? '0     : in_x + 1'b1;
  assign in_ym = (in_y == '0)     ? Y_LAST : in_y - 1'b1;
  assign in_yp = (in_y == Y_LAST) ? '0     : in_y + 1'b1;

  // control and move registers
  iclu_pkg::state_t state, state_next;
  logic [AW-1:0]    clr_addr;
  iclu_pkg::op_t    mv_op;
  logic [XW-1:0]    mv_x, mv_xm, mv_xp;
  logic [YW-1:0]    mv_y, mv_ym;
  logic [31:0]      mv_r1, mv_r2;
  logic             mv_pick;
  iclu_pkg::site_t  old_site, nb_yp, nb_ym, nb_xm;
  logic [CNT_W-1:0] occupancy, occupancy_next;
  iclu_pkg::site_t  res_old, res_new;

  logic accept;
  assign busy   = (state != iclu_pkg::S_IDLE);
  assign accept = start && !busy;

  // lattice memory
  iclu_pkg::site_t mem [DEPTH];
  iclu_pkg::site_t qa, qb, wd;
  logic [AW-1:0]   ra, rb, wa;
  logic            re, we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      qa <= mem[ra];
      qb <= mem[rb];
    end
  end

  always_comb begin
    re = 1'b0;
    ra = {in_x, in_y};
    rb = {in_x, in_yp};
    unique case (state)
      iclu_pkg::S_IDLE: begin
        re = accept;
        if (iclu_pkg::op_t'(op) == iclu_pkg::OP_CONTACT) begin
          unique case (iclu_pkg::dir_t'(direction))
            iclu_pkg::DIR_YM: rb = {in_x, in_ym};
            iclu_pkg::DIR_YP: rb = {in_x, in_yp};
            iclu_pkg::DIR_XM: rb = {in_xm, in_y};
            iclu_pkg::DIR_XP: rb = {in_xp, in_y};
            default:          rb = {in_x, in_yp};
          endcase
        end
      end
      iclu_pkg::S_RD1: begin
        re = (mv_op == iclu_pkg::OP_SPIN);
        ra = {mv_x, mv_ym};
        rb = {mv_xm, mv_y};
      end
      iclu_pkg::S_RD2: begin
        re = 1'b1;
        ra = {mv_xp, mv_y};
        rb = {mv_xm, mv_y};
      end
      default: ;
    endcase
  end

  // move evaluation
  iclu_pkg::site_t ev_old, ev_new;
  logic            ev_inc, ev_dec, ev_flip;
  logic [2:0]      ups, downs;
  logic signed [3:0] diff, s_eff;
  logic [THR_W-1:0] acc_thr;
  logic [THR_W-1:0] r1_ext, r2_ext;

  assign r1_ext = {1'b0, mv_r1};
  assign r2_ext = {1'b0, mv_r2};
  assign ev_old = (state == iclu_pkg::S_EVAL) ? old_site : qa;

  always_comb begin
    ups   = {2'd0, nb_yp == iclu_pkg::SITE_UP} + {2'd0, nb_ym == iclu_pkg::SITE_UP}
          + {2'd0, nb_xm == iclu_pkg::SITE_UP} + {2'd0, qa == iclu_pkg::SITE_UP};
    downs = {2'd0, nb_yp == iclu_pkg::SITE_DOWN} + {2'd0, nb_ym == iclu_pkg::SITE_DOWN}
          + {2'd0, nb_xm == iclu_pkg::SITE_DOWN} + {2'd0, qa == iclu_pkg::SITE_DOWN};
    diff  = signed'({1'b0, ups}) - signed'({1'b0, downs});
    // dE/2 is +S when J and E0 have opposite signs
    s_eff = (coupling_negative ^ (old_site == iclu_pkg::SITE_DOWN)) ? diff : -diff;
    case (s_eff)
      4'sd1:   acc_thr = accept_de2;
      4'sd2:   acc_thr = accept_de4;
      4'sd3:   acc_thr = accept_de6;
      4'sd4:   acc_thr = accept_de8;
      default: acc_thr = '0;
    endcase
    ev_flip = (s_eff <= 4'sd0) || (r2_ext < acc_thr);
  end

  always_comb begin
    ev_new = ev_old;
    ev_inc = 1'b0;
    ev_dec = 1'b0;
    if (state == iclu_pkg::S_RD1) begin
      if (ev_old == iclu_pkg::SITE_EMPTY) begin
        if (r1_ext < birth_threshold && qb != iclu_pkg::SITE_EMPTY) begin
          ev_new = qb;
          ev_inc = 1'b1;
        end
      end else if (ev_old == iclu_pkg::SITE_OCC) begin
        if (r1_ext < death_threshold) begin
          ev_new = iclu_pkg::SITE_EMPTY;
          ev_dec = 1'b1;
        end else if (r2_ext < polarize_threshold) begin
          ev_new = mv_pick ? iclu_pkg::SITE_DOWN : iclu_pkg::SITE_UP;
        end
      end
    end else if (ev_old inside {iclu_pkg::SITE_UP, iclu_pkg::SITE_DOWN}) begin
      if (r1_ext < death_threshold) begin
        ev_new = iclu_pkg::SITE_EMPTY;
        ev_dec = 1'b1;
      end else if (ev_flip) begin
        ev_new = (ev_old == iclu_pkg::SITE_UP) ? iclu_pkg::SITE_DOWN : iclu_pkg::SITE_UP;
      end
    end
  end

  logic finish;
  assign finish = (state == iclu_pkg::S_EVAL) ||
                  (state == iclu_pkg::S_RD1 && mv_op == iclu_pkg::OP_CONTACT);

  always_comb begin
    occupancy_next = occupancy;
    if (ev_inc) begin
      occupancy_next = occupancy + 1'b1;
    end else if (ev_dec && occupancy != '0) begin
      occupancy_next = occupancy - 1'b1;
    end
  end

  // write port: clearing pass, then write-back of the focal site
  always_comb begin
    we = 1'b0;
    wa = {mv_x, mv_y};
    wd = ev_new;
    if (state == iclu_pkg::S_CLEAR) begin
      we = 1'b1;
      wa = clr_addr;
      wd = (clr_addr == CENTRE) ? iclu_pkg::SITE_OCC : iclu_pkg::SITE_EMPTY;
    end else if (finish) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iclu_pkg::S_CLEAR: if (clr_addr == '1) state_next = iclu_pkg::S_IDLE;
      iclu_pkg::S_IDLE:  if (start) state_next = iclu_pkg::S_RD1;
      iclu_pkg::S_RD1: begin
        state_next = (mv_op == iclu_pkg::OP_SPIN) ? iclu_pkg::S_RD2 : iclu_pkg::S_IDLE;
      end
      iclu_pkg::S_RD2:   state_next = iclu_pkg::S_EVAL;
      iclu_pkg::S_EVAL:  state_next = iclu_pkg::S_IDLE;
      default:           state_next = iclu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iclu_pkg::S_CLEAR;
      clr_addr  <= '0;
      occupancy <= CNT_W'(1);
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == iclu_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish) begin
        occupancy <= occupancy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mv_op   <= iclu_pkg::op_t'(op);
      mv_x    <= in_x;
      mv_xm   <= in_xm;
      mv_xp   <= in_xp;
      mv_y    <= in_y;
      mv_ym   <= in_ym;
      mv_r1   <= rand_event;
      mv_r2   <= rand_second;
      mv_pick <= spin_pick;
    end
    if (state == iclu_pkg::S_RD1) begin
      old_site <= qa;
      nb_yp    <= qb;
    end
    if (state == iclu_pkg::S_RD2) begin
      nb_ym <= qa;
      nb_xm <= qb;
    end
    if (finish) begin
      res_old <= ev_old;
      res_new <= ev_new;
    end
  end

  assign old_state      = res_old;
  assign new_state      = res_new;
  assign occupied_count = occupancy;

  `ICLU_ASSERT_IMP(a_done_idle, done, state == iclu_pkg::S_IDLE, "result outside idle")
  `ICLU_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `ICLU_ASSERT_IMP(a_write_phase, we,
    state == iclu_pkg::S_CLEAR || state == iclu_pkg::S_RD1 || state == iclu_pkg::S_EVAL,
    "lattice write outside a write phase")
  `ICLU_ASSERT_NXT(a_occ_step, 1'b1,
    $past(rst) || occupancy == $past(occupancy) ||
    occupancy == $past(occupancy) + 1'b1 || occupancy == $past(occupancy) - 1'b1,
    "occupancy moved by more than one")

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for ising_contact_lattice_update: directed and random moves
// checked against a lattice predictor, with register changes over the APB port.
// Depends on iclu_pkg and the ising_contact_lattice_update RTL.
`timescale 1ns / 100ps

module tb_top;
  import iclu_pkg::*;

  localparam int LX = 256;
  localparam int LY = 256;
  localparam logic [31:0] DRAW_MAX = 32'hFFFF_FFFF;
  localparam logic [32:0] THR_ALWAYS = 33'h1_0000_0000;

  typedef struct {
    op_t         op;
    logic [7:0]  x;
    logic [7:0]  y;
    dir_t        dir;
    logic [31:0] r_event;
    logic [31:0] r_second;
    logic        pick;
    int unsigned gap;
  } move_t;

  typedef struct {
    site_t       old_s;
    site_t       new_s;
    logic [16:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = 1'b0;
  logic [7:0] site_x = '0;
  logic [7:0] site_y = '0;
  logic [1:0] direction = '0;
  logic [31:0] rand_event = '0;
  logic [31:0] rand_second = '0;
  logic spin_pick = 1'b0;
  logic done;
  logic [1:0] old_state;
  logic [1:0] new_state;
  logic [16:0] occupied_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  ising_contact_lattice_update #(.LATTICE_X(LX), .LATTICE_Y(LY)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .site_x(site_x), .site_y(site_y), .direction(direction),
    .rand_event(rand_event), .rand_second(rand_second), .spin_pick(spin_pick),
    .done(done), .old_state(old_state), .new_state(new_state),
    .occupied_count(occupied_count), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // lattice predictor state and register copy
  site_t       lat_m [LX*LY];
  logic [16:0] occ_m;
  logic        coupling_m;
  logic [32:0] birth_m, death_m, polar_m;
  logic [32:0] accept_m [4];

  move_t    pending_q [$];
  outcome_t expected_q [$];
  move_t    cur_mv;
  int unsigned idle_cnt = 0;

  int errors = 0;
  int checked = 0;
  int settings = 0;
  int n_birth = 0, n_death = 0, n_polar = 0, n_flip = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned sidx(int unsigned x, int unsigned y);
    return (x % LX) * LY + (y % LY);
  endfunction

  function automatic int spin_val(site_t s);
    if (s == SITE_UP) return 1;
    if (s == SITE_DOWN) return -1;
    return 0;
  endfunction

  function automatic outcome_t apply_move(move_t m);
    int unsigned x, y, xm, xp, ym, yp, here;
    site_t prev, nxt, nb;
    int sum, e0, de;
    bit flip;
    outcome_t o;
    x = m.x % LX;
    y = m.y % LY;
    xm = (x == 0) ? LX - 1 : x - 1;
    xp = (x + 1 >= LX) ? 0 : x + 1;
    ym = (y == 0) ? LY - 1 : y - 1;
    yp = (y + 1 >= LY) ? 0 : y + 1;
    here = sidx(x, y);
    prev = lat_m[here];
    nxt = prev;
    if (m.op == OP_CONTACT) begin
      if (prev == SITE_EMPTY) begin
        case (m.dir)
          DIR_YM: nb = lat_m[sidx(x, ym)];
          DIR_YP: nb = lat_m[sidx(x, yp)];
          DIR_XM: nb = lat_m[sidx(xm, y)];
          default: nb = lat_m[sidx(xp, y)];
        endcase
        if (m.r_event < birth_m && nb != SITE_EMPTY) begin
          nxt = nb;
          occ_m++;
          n_birth++;
        end
      end else if (prev == SITE_OCC) begin
        if (m.r_event < death_m) begin
          nxt = SITE_EMPTY;
          if (occ_m != 0) occ_m--;
          n_death++;
        end else if (m.r_second < polar_m) begin
          nxt = m.pick ? SITE_DOWN : SITE_UP;
          n_polar++;
        end
      end
    end else if (prev == SITE_UP || prev == SITE_DOWN) begin
      if (m.r_event < death_m) begin
        nxt = SITE_EMPTY;
        if (occ_m != 0) occ_m--;
        n_death++;
      end else begin
        sum = spin_val(lat_m[sidx(x, yp)]) + spin_val(lat_m[sidx(x, ym)]) +
              spin_val(lat_m[sidx(xm, y)]) + spin_val(lat_m[sidx(xp, y)]);
        e0 = (prev == SITE_UP) ? 1 : -1;
        de = (coupling_m ? 2 : -2) * e0 * sum;
        if (de <= 0) flip = 1'b1;
        else if (de <= 8) flip = (m.r_second < accept_m[de / 2 - 1]);
        else flip = 1'b0;
        if (flip) begin
          nxt = (prev == SITE_UP) ? SITE_DOWN : SITE_UP;
          n_flip++;
        end
      end
    end
    lat_m[here] = nxt;
    o.old_s = prev;
    o.new_s = nxt;
    o.count = occ_m;
    return o;
  endfunction

  function automatic int unsigned rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] rand_draw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return DRAW_MAX;
    if (r == 2) return $urandom_range(0, 1048575);
    return $urandom;
  endfunction

  function automatic logic [32:0] rand_thr();
    if ($urandom_range(0, 7) == 0) return THR_ALWAYS;
    return {1'b0, 32'($urandom)};
  endfunction

  function automatic move_t mk(op_t o, logic [7:0] x, logic [7:0] y, dir_t d,
                               logic [31:0] r1, logic [31:0] r2, logic pk);
    move_t m;
    m.op = o;
    m.x = x;
    m.y = y;
    m.dir = d;
    m.r_event = r1;
    m.r_second = r2;
    m.pick = pk;
    m.gap = rand_gap();
    return m;
  endfunction

  // most moves land on the live clusters near the center and the wrapped corner
  function automatic move_t cluster_move();
    logic [7:0] x, y;
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      x = 8'(124 + $urandom_range(0, 8));
      y = 8'(124 + $urandom_range(0, 8));
    end else if (r < 85) begin
      x = $urandom_range(0, 1) ? 8'(254 + $urandom_range(0, 3)) : 8'(127 + $urandom_range(0, 2));
      y = 8'(254 + $urandom_range(0, 3));
    end else begin
      x = 8'($urandom);
      y = 8'($urandom);
    end
    return mk(($urandom_range(0, 99) < 55) ? OP_CONTACT : OP_SPIN, x, y,
              dir_t'($urandom_range(0, 3)), rand_draw(), rand_draw(),
              1'($urandom_range(0, 1)));
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0 || start) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [32:0] val);
    logic [63:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COUPLING: coupling_m = val[0];
      REG_BIRTH:    birth_m = val;
      REG_DEATH:    death_m = val;
      REG_POLARIZE: polar_m = val;
      REG_ACC_DE2:  accept_m[0] = val;
      REG_ACC_DE4:  accept_m[1] = val;
      REG_ACC_DE6:  accept_m[2] = val;
      REG_ACC_DE8:  accept_m[3] = val;
      default: ;
    endcase
    want = (idx == REG_COUPLING) ? {63'b0, val[0]} : {31'b0, val};
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata (reg %s): expected %0h, got %0h", idx.name(), want, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(logic cpl, logic [32:0] birth, logic [32:0] death,
                               logic [32:0] polar, logic [32:0] a2, logic [32:0] a4,
                               logic [32:0] a6, logic [32:0] a8);
    reg_write(REG_COUPLING, {32'b0, cpl});
    reg_write(REG_BIRTH, birth);
    reg_write(REG_DEATH, death);
    reg_write(REG_POLARIZE, polar);
    reg_write(REG_ACC_DE2, a2);
    reg_write(REG_ACC_DE4, a4);
    reg_write(REG_ACC_DE6, a6);
    reg_write(REG_ACC_DE8, a8);
    settings++;
  endtask

  task automatic run_cluster(int n);
    @(negedge clk);
    repeat (n) pending_q.push_back(cluster_move());
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin : drive
    logic go;
    if (rst) begin
      start <= 1'b0;
      idle_cnt = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_q.push_back(apply_move(cur_mv));
        go = 1'b0;
      end
      if (!go && pending_q.size() != 0) begin
        if (idle_cnt < pending_q[0].gap) begin
          idle_cnt++;
        end else begin
          cur_mv = pending_q.pop_front();
          idle_cnt = 0;
          op <= cur_mv.op;
          site_x <= cur_mv.x;
          site_y <= cur_mv.y;
          direction <= cur_mv.dir;
          rand_event <= cur_mv.r_event;
          rand_second <= cur_mv.r_second;
          spin_pick <= cur_mv.pick;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: old %0d new %0d count %0d",
               old_state, new_state, occupied_count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (old_state !== want.old_s) begin
          $error("old_state: expected %0d, got %0d", want.old_s, old_state);
          errors++;
        end
        if (new_state !== want.new_s) begin
          $error("new_state: expected %0d, got %0d", want.new_s, new_state);
          errors++;
        end
        if (occupied_count !== want.count) begin
          $error("occupied_count: expected %0d, got %0d", want.count, occupied_count);
          errors++;
        end
        checked++;
      end
    end
  end

  initial begin
    for (int i = 0; i < LX * LY; i++) lat_m[i] = SITE_EMPTY;
    lat_m[sidx(LX / 2, LY / 2)] = SITE_OCC;
    occ_m = 17'd1;
    coupling_m = RST_COUPLING;
    birth_m = RST_BIRTH;
    death_m = RST_DEATH;
    polar_m = RST_POLARIZE;
    accept_m[0] = RST_ACC_DE2;
    accept_m[1] = RST_ACC_DE4;
    accept_m[2] = RST_ACC_DE6;
    accept_m[3] = RST_ACC_DE8;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed moves under reset settings
    @(negedge clk);
    pending_q.push_back(mk(OP_SPIN, 128, 128, DIR_YM, DRAW_MAX, 0, 0));
    pending_q.push_back(mk(OP_CONTACT, 0, 0, DIR_YM, 0, 0, 0));
    pending_q.push_back(mk(OP_CONTACT, 255, 255, DIR_XP, 0, DRAW_MAX, 1));
    pending_q.push_back(mk(OP_CONTACT, 128, 127, DIR_YP, DRAW_MAX, 0, 0));
    pending_q.push_back(mk(OP_CONTACT, 128, 129, DIR_YM, 0, 0, 1));
    pending_q.push_back(mk(OP_CONTACT, 127, 128, DIR_XP, DRAW_MAX, DRAW_MAX, 0));
    pending_q.push_back(mk(OP_CONTACT, 129, 128, DIR_XM, 32'h8000_0000, 0, 1));
    pending_q.push_back(mk(OP_CONTACT, 128, 128, DIR_YM, DRAW_MAX, 0, 0));
    pending_q.push_back(mk(OP_CONTACT, 128, 127, DIR_YM, 32'd429497, 0, 1));
    pending_q.push_back(mk(OP_CONTACT, 128, 129, DIR_YM, DRAW_MAX, DRAW_MAX, 0));
    pending_q.push_back(mk(OP_CONTACT, 128, 128, DIR_XP, 0, 0, 1));
    pending_q.push_back(mk(OP_SPIN, 128, 128, DIR_YM, DRAW_MAX, 0, 0));
    pending_q.push_back(mk(OP_SPIN, 128, 128, DIR_YM, DRAW_MAX, DRAW_MAX, 0));
    pending_q.push_back(mk(OP_SPIN, 128, 128, DIR_YM, DRAW_MAX, 0, 1));
    pending_q.push_back(mk(OP_SPIN, 128, 127, DIR_YM, 0, 0, 0));
    pending_q.push_back(mk(OP_CONTACT, 129, 128, DIR_YM, 32'd429496, DRAW_MAX, 0));
    pending_q.push_back(mk(OP_SPIN, 129, 128, DIR_YM, 0, 0, 0));
    pending_q.push_back(mk(OP_SPIN, 128, 129, DIR_YM, 0, 0, 0));
    wait_drained();

    // grow corridors from the center to both torus seams, then across them
    load_settings(1'b0, THR_ALWAYS, 33'd0, 33'h0_8000_0000,
                  rand_thr(), rand_thr(), rand_thr(), rand_thr());
    @(negedge clk);
    for (int yy = 127; yy >= 0; yy--) begin
      pending_q.push_back(mk(OP_CONTACT, 128, 8'(yy), DIR_YP, $urandom, $urandom,
                             1'($urandom_range(0, 1))));
      if ($urandom_range(0, 9) != 0) pending_q[$].gap = 0;
    end
    pending_q.push_back(mk(OP_CONTACT, 128, 255, DIR_YP, $urandom, $urandom, 1'b0));
    for (int xx = 127; xx >= 0; xx--) begin
      pending_q.push_back(mk(OP_CONTACT, 8'(xx), 0, DIR_XP, $urandom, $urandom,
                             1'($urandom_range(0, 1))));
      if ($urandom_range(0, 9) != 0) pending_q[$].gap = 0;
    end
    pending_q.push_back(mk(OP_CONTACT, 255, 0, DIR_XP, $urandom, $urandom, 1'b1));
    pending_q.push_back(mk(OP_CONTACT, 0, 255, DIR_YP, $urandom, $urandom, 1'b0));
    wait_drained();

    load_settings(1'b1, rand_thr(), 33'h0_1000_0000, rand_thr(),
                  rand_thr(), rand_thr(), rand_thr(), rand_thr());
    run_cluster(120);
    load_settings(1'b0, 33'd0, THR_ALWAYS, 33'd0,
                  THR_ALWAYS, THR_ALWAYS, THR_ALWAYS, THR_ALWAYS);
    run_cluster(30);
    load_settings(1'b1, THR_ALWAYS, 33'd0, THR_ALWAYS, 33'd0, 33'd0, 33'd0, 33'd0);
    run_cluster(80);
    load_settings(1'b0, RST_BIRTH, RST_DEATH, RST_POLARIZE,
                  RST_ACC_DE2, RST_ACC_DE4, RST_ACC_DE6, RST_ACC_DE8);
    run_cluster(70);

    $display("Checked %0d moves: %0d births, %0d deaths, %0d polarizations, %0d flips.",
             checked, n_birth, n_death, n_polar, n_flip);
    $display("Ran %0d register settings, both coupling signs and threshold extremes.",
             settings + 1);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
